>>> src/akvb_pkg.sv
// ----------------------------------------------------------------------------
// akvb_pkg
// Shared types and constants of the associative key-value buffer: operation
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package akvb_pkg;

    localparam int KEY_W         = 64;
    localparam int VAL_W         = 64;
    localparam int FUNC_W        = 2;
    localparam int NUM_SLOTS_DEF = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REMOVE = 2'd2
    } func_e_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic val_write;
        logic key_write;
        logic use_free;
        logic clr_valid;
        logic val_read;
        logic ok;
        logic respond;
    } ctrl_cmd_t;

    typedef struct packed {
        func_e_t func;
        logic    hit;
        logic    has_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> src/akvb_ctrl.sv
// ----------------------------------------------------------------------------
// akvb_ctrl
// Request sequencer: capture, compare, apply and respond, deciding the slot
// update from the match and free-slot status of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module akvb_ctrl
    import akvb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MATCH = 4'b0010,
        ST_APPLY = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY:
            begin
                unique case (status.func)
                    FUNC_INSERT:
                    begin
                        if (status.hit)
                        begin
                            cmd.val_write = 1'b1;
                            cmd.ok        = 1'b1;
                        end
                        else if (status.has_free)
                        begin
                            cmd.val_write = 1'b1;
                            cmd.key_write = 1'b1;
                            cmd.use_free  = 1'b1;
                            cmd.ok        = 1'b1;
                        end
                    end
                    FUNC_LOOKUP:
                    begin
                        cmd.val_read = status.hit;
                        cmd.ok       = status.hit;
                    end
                    FUNC_REMOVE:
                    begin
                        cmd.clr_valid = status.hit;
                        cmd.ok        = status.hit;
                    end
                    default:
                    begin
                        cmd.ok = 1'b0;
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.respond = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepting a beat");

    a_respond_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> !busy)
        else $error("busy still high after result beat");

    a_ok_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ok && !cmd.use_free) |-> status.hit)
        else $error("success without a matching slot");
`endif

endmodule

`default_nettype wire

>>> src/akvb_dp.sv
// ----------------------------------------------------------------------------
// akvb_dp
// Slot storage and matching: request registers, per-slot key registers with
// parallel compare, valid bits, value memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module akvb_dp
    import akvb_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    input  logic [FUNC_W-1:0] func,
    input  logic [KEY_W-1:0]  req_key,
    input  logic [VAL_W-1:0]  req_value,
    output dp_status_t        status,
    output logic              success,
    output logic [VAL_W-1:0]  read_value
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic [FUNC_W-1:0]    func_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [KEY_W-1:0]     slot_key_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_valid_reg;
    logic [VAL_W-1:0]     val_mem [NUM_SLOTS];
    logic [VAL_W-1:0]     rdata_reg;
    logic [NUM_SLOTS-1:0] match_vec;
    logic                 hit_any;
    logic [IDX_W-1:0]     hit_idx;
    logic                 free_any;
    logic [IDX_W-1:0]     free_idx;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic                 free_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic [IDX_W-1:0]     wr_idx;
    logic                 ok_reg;
    logic                 read_sel_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            key_reg  <= req_key;
            val_reg  <= req_value;
        end
    end

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_slot
        assign match_vec[g] = slot_valid_reg[g] && (slot_key_reg[g] == key_reg);

        always_ff @(posedge clk)
        begin
            if (cmd.key_write && (free_idx_reg == IDX_W'(g)))
            begin
                slot_key_reg[g] <= key_reg;
            end
        end
    end

    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            slot_valid_reg <= '0;
            ok_reg         <= 1'b0;
            read_sel_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.compare)
            begin
                hit_reg  <= hit_any;
                free_reg <= free_any;
            end
            if (cmd.key_write)
            begin
                slot_valid_reg[free_idx_reg] <= 1'b1;
            end
            if (cmd.clr_valid)
            begin
                slot_valid_reg[hit_idx_reg] <= 1'b0;
            end
            if (cmd.respond)
            begin
                ok_reg       <= 1'b0;
                read_sel_reg <= 1'b0;
            end
            else if (cmd.ok || cmd.val_read)
            begin
                ok_reg       <= cmd.ok;
                read_sel_reg <= cmd.val_read;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            hit_idx_reg  <= hit_idx;
            free_idx_reg <= free_idx;
        end
    end

    assign wr_idx = cmd.use_free ? free_idx_reg : hit_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.val_write)
        begin
            val_mem[wr_idx] <= val_reg;
        end
        if (cmd.val_read)
        begin
            rdata_reg <= val_mem[hit_idx_reg];
        end
    end

    assign status.func     = func_e_t'(func_reg);
    assign status.hit      = hit_reg;
    assign status.has_free = free_reg;

    assign success    = cmd.respond && ok_reg;
    assign read_value = (cmd.respond && read_sel_reg) ? rdata_reg : '0;

`ifndef SYNTH
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compare |-> $onehot0(match_vec))
        else $error("key held in more than one slot");

    a_fill_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.key_write |-> !slot_valid_reg[free_idx_reg])
        else $error("fill targets an occupied slot");

    a_remove_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_valid |-> slot_valid_reg[hit_idx_reg])
        else $error("remove targets an empty slot");
`endif

endmodule

`default_nettype wire

>>> src/associative_key_value_buffer.sv
// ----------------------------------------------------------------------------
// associative_key_value_buffer
// Fully associative key-value store with insert, lookup and remove requests.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. Each request
// yields one result beat, shown for a single cycle with done high; the
// receiver cannot hold it off, so sample success and read_value while done is high.
// busy stays high from acceptance until the result beat has been shown, so a
// new request is taken only after the last one has finished. The request is
// captured on acceptance; then the key is compared against all slots and the
// lowest free slot is picked, the slot is updated or the value memory read,
// and the result is presented. Slots start empty after reset with no clearing
// pass.
// ----------------------------------------------------------------------------
`default_nettype none

module associative_key_value_buffer
    import akvb_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [KEY_W-1:0]  req_key,
    input  logic [VAL_W-1:0]  req_value,
    output logic              done,
    output logic              success,
    output logic [VAL_W-1:0]  read_value
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    akvb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    akvb_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (func),
        .req_key    (req_key),
        .req_value  (req_value),
        .status     (status),
        .success    (success),
        .read_value (read_value)
    );

    assign done = cmd.respond;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the associative key-value buffer. A shadow store
// predicts success and read_value for every accepted request beat; each result
// beat is compared field by field with the oldest prediction. A short directed
// run covers the empty, full, update, miss and spare-selector cases, then
// random traffic alternates fill-biased and drain-biased phases over a small
// key pool, with random idle bursts on the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import akvb_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int                STALL_LIMIT = 1000;
    localparam int                POOL_SIZE   = 24;
    localparam int                BLOCK_ITEMS = 50;
    localparam int                NUM_BLOCKS  = 37;
    localparam int                CALM_BLOCKS = 4;
    localparam logic [KEY_W-1:0]  ALL_ONES    = {KEY_W{1'b1}};

    typedef struct {
        bit             ok;
        bit [VAL_W-1:0] value;
    } kv_result_t;

    class kv_shadow_store;
        bit [KEY_W-1:0] slot_key   [NUM_SLOTS_DEF];
        bit [VAL_W-1:0] slot_value [NUM_SLOTS_DEF];
        bit             slot_valid [NUM_SLOTS_DEF];
        kv_result_t     pending_results [$];
        int             error_count;

        function new();
            error_count = 0;
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
            begin
                slot_valid[i] = 1'b0;
            end
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            error_count++;
        endtask

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(input logic [FUNC_W-1:0] f,
                                   input logic [KEY_W-1:0] k,
                                   input logic [VAL_W-1:0] v);
            int         hit;
            int         vacant;
            kv_result_t res;
            hit    = -1;
            vacant = -1;
            res.ok    = 1'b0;
            res.value = '0;
            for (int i = NUM_SLOTS_DEF - 1; i >= 0; i--)
            begin
                if (slot_valid[i] && slot_key[i] == k)
                    hit = i;
                if (!slot_valid[i])
                    vacant = i;
            end
            if (f == FUNC_INSERT)
            begin
                if (hit >= 0)
                begin
                    slot_value[hit] = v;
                    res.ok = 1'b1;
                end
                else if (vacant >= 0)
                begin
                    slot_key[vacant]   = k;
                    slot_value[vacant] = v;
                    slot_valid[vacant] = 1'b1;
                    res.ok = 1'b1;
                end
            end
            else if (f == FUNC_LOOKUP)
            begin
                if (hit >= 0)
                begin
                    res.value = slot_value[hit];
                    res.ok    = 1'b1;
                end
            end
            else if (f == FUNC_REMOVE)
            begin
                if (hit >= 0)
                begin
                    slot_valid[hit] = 1'b0;
                    res.ok = 1'b1;
                end
            end
            pending_results.push_back(res);
        endfunction

        task check_result(input logic ok, input logic [VAL_W-1:0] value);
            kv_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                report("result beat with no request outstanding");
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (ok !== exp_res.ok)
                    report($sformatf("success %b, expected %b", ok, exp_res.ok));
                if (value !== exp_res.value)
                    report($sformatf("read_value %h, expected %h", value, exp_res.value));
            end
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  req_key;
    logic [VAL_W-1:0]  req_value;
    logic              done;
    logic              success;
    logic [VAL_W-1:0]  read_value;

    kv_shadow_store    store;
    int                stall_count;
    logic [KEY_W-1:0]  key_pool [POOL_SIZE];

    associative_key_value_buffer uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .req_key    (req_key),
        .req_value  (req_value),
        .done       (done),
        .success    (success),
        .read_value (read_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        func      = FUNC_INSERT;
        req_key   = '0;
        req_value = '0;
        store     = new();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (done)
                store.check_result(success, read_value);
            if (stall_count >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
        else
        begin
            stall_count <= 0;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap(input bit idle_on);
        if (idle_on && $urandom_range(0, 2) == 0)
            return $urandom_range(1, 5);
        return 0;
    endfunction

    // Hold the beat until taken, then drop start for an idle burst if asked.
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                         input logic [VAL_W-1:0] v, input int gap);
        start     <= 1'b1;
        func      <= f;
        req_key   <= k;
        req_value <= v;
        do @(posedge clk); while (busy);
        store.note_request(f, k, v);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        logic [KEY_W-1:0] fill_keys [14];
        for (int i = 0; i < 14; i++)
            fill_keys[i] = rand64();
        issue(FUNC_LOOKUP, ALL_ONES, ALL_ONES, pick_gap(1'b1));
        issue(FUNC_REMOVE, '0, ALL_ONES, pick_gap(1'b1));
        issue(FUNC_SPARE, ALL_ONES, ALL_ONES, pick_gap(1'b1));
        issue(FUNC_INSERT, '0, '0, pick_gap(1'b1));
        issue(FUNC_INSERT, ALL_ONES, ALL_ONES, pick_gap(1'b1));
        issue(FUNC_LOOKUP, '0, ALL_ONES, pick_gap(1'b1));
        issue(FUNC_LOOKUP, ALL_ONES, '0, pick_gap(1'b1));
        issue(FUNC_INSERT, ALL_ONES, 64'h5a5a_a5a5_0f0f_f0f0, pick_gap(1'b1));
        issue(FUNC_LOOKUP, ALL_ONES, '0, pick_gap(1'b1));
        for (int i = 0; i < 14; i++)
            issue(FUNC_INSERT, fill_keys[i], rand64(), pick_gap(1'b1));
        issue(FUNC_INSERT, 64'h8000_0000_0000_0001, ALL_ONES, pick_gap(1'b1));
        issue(FUNC_INSERT, fill_keys[7], 64'h0123_4567_89ab_cdef, pick_gap(1'b1));
        issue(FUNC_REMOVE, fill_keys[3], '0, pick_gap(1'b1));
        issue(FUNC_INSERT, 64'h8000_0000_0000_0001, rand64(), pick_gap(1'b1));
        issue(FUNC_LOOKUP, 64'h8000_0000_0000_0001, '0, pick_gap(1'b1));
        issue(FUNC_LOOKUP, fill_keys[3], '0, pick_gap(1'b1));
    endtask

    task automatic run_random();
        bit                fill_phase;
        bit                idle_on;
        int                r;
        logic [FUNC_W-1:0] f;
        logic [KEY_W-1:0]  k;
        logic [VAL_W-1:0]  v;
        for (int blk = 0; blk < NUM_BLOCKS; blk++)
        begin
            fill_phase = (blk % 2 == 0);
            idle_on    = (blk < NUM_BLOCKS - CALM_BLOCKS) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < BLOCK_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (fill_phase)
                    f = (r < 55) ? FUNC_INSERT : (r < 85) ? FUNC_LOOKUP :
                        (r < 97) ? FUNC_REMOVE : FUNC_SPARE;
                else
                    f = (r < 20) ? FUNC_INSERT : (r < 50) ? FUNC_LOOKUP :
                        (r < 95) ? FUNC_REMOVE : FUNC_SPARE;
                k = ($urandom_range(0, 9) == 0) ? rand64()
                                                : key_pool[$urandom_range(0, POOL_SIZE - 1)];
                r = $urandom_range(0, 19);
                v = (r == 0) ? '0 : (r == 1) ? ALL_ONES : rand64();
                issue(f, k, v, pick_gap(idle_on));
            end
        end
    endtask

    initial
    begin
        key_pool[0] = '0;
        key_pool[1] = ALL_ONES;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = rand64();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        start <= 1'b0;
        while (store.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (store.error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
src/akvb_pkg.sv
src/akvb_ctrl.sv
src/akvb_dp.sv
src/associative_key_value_buffer.sv
dv/testbench.sv
